// ===== sv/llg_pkg.sv =====
package llg_pkg;

   localparam int FRAC_BITS = 32;
   localparam int WORD_W    = 64;
   localparam int GAMMA_W   = 63;
   localparam int DAMP_W    = 63;
   localparam int MUL_LAT   = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREC  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CORR  = 2'd2;

   typedef logic signed [WORD_W-1:0] word_type;

   localparam word_type FX_ONE   = word_type'(64'd1 << FRAC_BITS);
   localparam word_type WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   // Exact sum on 65 bits, clamped to the signed 64-bit range.
   function automatic word_type sat_add(word_type a, word_type b);
      logic signed [WORD_W:0] s;
      s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
      if (s[WORD_W] != s[WORD_W-1]) begin
         return s[WORD_W] ? WORD_MIN : WORD_MAX;
      end
      return s[WORD_W-1:0];
   endfunction

   function automatic word_type sat_sub(word_type a, word_type b);
      logic signed [WORD_W:0] s;
      s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
      if (s[WORD_W] != s[WORD_W-1]) begin
         return s[WORD_W] ? WORD_MIN : WORD_MAX;
      end
      return s[WORD_W-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] mag64(word_type a);
      logic [WORD_W-1:0] u;
      u = a;
      return a[WORD_W-1] ? (~u + 64'd1) : u;
   endfunction

   function automatic word_type from_mag(logic [WORD_W-1:0] m, logic neg);
      if (neg) begin
         return m[WORD_W-1] ? WORD_MIN : word_type'(~m + 64'd1);
      end
      return m[WORD_W-1] ? WORD_MAX : word_type'(m);
   endfunction

endpackage

// ===== sv/llg_ifs.sv =====
interface llg_req_if;
   import llg_pkg::*;
   logic                     valid;
   logic                     ready;
   word_type                 m_x;
   word_type                 m_y;
   word_type                 m_z;
   word_type                 h_x;
   word_type                 h_y;
   word_type                 h_z;
   logic [DAMP_W-1:0]        damping;
   logic                     pinned;
   logic                     last_cell;

   modport source (output valid, m_x, m_y, m_z, h_x, h_y, h_z, damping, pinned, last_cell,
                   input ready);
   modport sink (input valid, m_x, m_y, m_z, h_x, h_y, h_z, damping, pinned, last_cell,
                 output ready);
endinterface

interface llg_rsp_if;
   import llg_pkg::*;
   logic     valid;
   logic     ready;
   word_type dm_x;
   word_type dm_y;
   word_type dm_z;
   logic     last_out;

   modport source (output valid, dm_x, dm_y, dm_z, last_out, input ready);
   modport sink (input valid, dm_x, dm_y, dm_z, last_out, output ready);
endinterface

// ===== sv/llg_rhs_cell.sv =====
// Channel | Direction | Contents
// req     | in        | m_x m_y m_z h_x h_y h_z damping pinned last_cell
// rsp     | out       | dm_x dm_y dm_z last_out
// csr     | in        | csr_wr_en csr_index csr_wdata (write only)
//
// One cell enters per cycle while the skid register is empty. The pipeline
// depth comes from the 63-stage quotient pipeline for gamma/(1+alpha^2), the
// 48-stage square-root pipeline and the multipliers.
// A one-word skid register behind the output stage holds a result that is not
// taken; while it is full the whole pipeline holds. Reset clears the valid bits
// and loads the register defaults.
module llg_rhs_cell import llg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   llg_req_if.sink              req,
   llg_rsp_if.source            rsp,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata
);

   localparam int L     = MUL_LAT;
   localparam int QB    = GAMMA_W;
   localparam int SQB   = (62 + FRAC_BITS) / 2 + 1;
   localparam int NW    = WORD_W + FRAC_BITS;
   localparam int TW    = WORD_W + 1 + FRAC_BITS;
   localparam int T_DOT = L + 2;
   localparam int T_OMM = L + 3;
   localparam int T_HP  = 2 * L + 3;
   localparam int T_CR  = T_HP + L + 1;
   localparam int T_T   = T_CR + 1;
   localparam int T_G   = L + 3 + QB;
   localparam int T_DM  = T_G + L;
   localparam int T_S   = T_DM + L + 2;
   localparam int T_R   = T_S + 1 + SQB;
   localparam int T_C   = T_R + 1;
   localparam int T_K   = T_C + L;
   localparam int T_KM  = T_K + L;
   localparam int T_OUT = T_KM + 1;

   // Configuration registers.
   logic [GAMMA_W-1:0] gamma_ff;
   logic               prec_ff;
   word_type           corr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= GAMMA_W'(64'd1 << FRAC_BITS);
         prec_ff  <= 1'b1;
         corr_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GAMMA: gamma_ff <= csr_wdata[GAMMA_W-1:0];
            CSR_PREC:  prec_ff  <= csr_wdata[0];
            CSR_CORR:  corr_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   logic en;
   logic skid_v_ff;
   logic [T_OUT:0] v_ff;

   assign en        = !skid_v_ff;
   assign req.ready = en;

   // Delay lines and stage registers.
   word_type    m_p   [0:T_K][3];
   word_type    h_p   [0:T_DOT][3];
   word_type    a_p   [0:T_HP];
   logic [1:0]  ctl_p [0:T_KM];
   word_type    mm01_ff, mm2_ff, mh01_ff, mh2_ff, den_ff;
   word_type    mm_ff, mh_ff;
   word_type    omm_p [T_OMM:T_C];
   word_type    hp_ff [3];
   word_type    cr_ff [3];
   word_type    hpa_ff [3];
   word_type    t_p   [T_T:T_G][3];
   word_type    negg_ff;
   word_type    dm_p  [T_DM+1:T_KM][3];
   word_type    s01_ff, s2_ff, s_ff;
   word_type    c_ff;
   word_type    out_ff [3];
   logic        last_ff;

   // Multiplier outputs.
   word_type    mmp [3];
   word_type    mhp [3];
   word_type    aap;
   word_type    hp1 [3];
   word_type    hp2 [3];
   word_type    cra [3];
   word_type    crb [3];
   word_type    hpa [3];
   word_type    dm_w [3];
   word_type    sp [3];
   word_type    kp;
   word_type    kmp [3];

   // Quotient pipeline for g = gamma * 2^F / den, one bit per stage.
   logic [63:0]   div_rem_ff [0:QB];
   logic [QB-1:0] div_q_ff   [0:QB];
   logic [QB-1:0] div_n_ff   [0:QB];
   logic [63:0]   div_den_ff [0:QB];
   logic [63:0]   div_rem_in [1:QB];
   logic [QB-1:0] div_q_in   [1:QB];
   logic [NW-1:0] div_num;

   assign div_num = (NW'(gamma_ff) << FRAC_BITS) + NW'($unsigned(den_ff) >> 1);

   always_comb begin
      int          b;
      logic [63:0] sh;
      for (int j = 1; j <= QB; j++) begin
         b  = QB - j;
         sh = {div_rem_ff[j-1][62:0], div_n_ff[j-1][b]};
         if (sh >= div_den_ff[j-1]) begin
            div_rem_in[j] = sh - div_den_ff[j-1];
            div_q_in[j]   = div_q_ff[j-1] | (QB'(1) << b);
         end else begin
            div_rem_in[j] = sh;
            div_q_in[j]   = div_q_ff[j-1];
         end
      end
   end

   // Square-root pipeline, remainder form, one result bit per stage.
   logic [TW-1:0]  sq_rem_ff [0:SQB];
   logic [SQB-1:0] sq_r_ff   [0:SQB];
   logic [TW-1:0]  sq_rem_in [1:SQB];
   logic [SQB-1:0] sq_r_in   [1:SQB];
   logic [63:0]    six_r;

   always_comb begin
      int            b;
      logic [TW-1:0] trial;
      for (int j = 1; j <= SQB; j++) begin
         b     = SQB - j;
         trial = (TW'(sq_r_ff[j-1]) << (b + 1)) | (TW'(1) << (2 * b));
         if (sq_rem_ff[j-1] >= trial) begin
            sq_rem_in[j] = sq_rem_ff[j-1] - trial;
            sq_r_in[j]   = sq_r_ff[j-1] | (SQB'(1) << b);
         end else begin
            sq_rem_in[j] = sq_rem_ff[j-1];
            sq_r_in[j]   = sq_r_ff[j-1];
         end
      end
   end

   assign six_r = (64'(sq_r_ff[SQB]) << 2) + (64'(sq_r_ff[SQB]) << 1);

   always_ff @(posedge clock) begin
      if (en) begin
         m_p[0][0] <= req.m_x;
         m_p[0][1] <= req.m_y;
         m_p[0][2] <= req.m_z;
         h_p[0][0] <= req.h_x;
         h_p[0][1] <= req.h_y;
         h_p[0][2] <= req.h_z;
         a_p[0]    <= {1'b0, req.damping};
         ctl_p[0]  <= {req.pinned, req.last_cell};
         for (int k = 1; k <= T_K; k++) m_p[k] <= m_p[k-1];
         for (int k = 1; k <= T_DOT; k++) h_p[k] <= h_p[k-1];
         for (int k = 1; k <= T_HP; k++) a_p[k] <= a_p[k-1];
         for (int k = 1; k <= T_KM; k++) ctl_p[k] <= ctl_p[k-1];

         mm01_ff <= sat_add(mmp[0], mmp[1]);
         mm2_ff  <= mmp[2];
         mh01_ff <= sat_add(mhp[0], mhp[1]);
         mh2_ff  <= mhp[2];
         den_ff  <= sat_add(FX_ONE, aap);
         mm_ff   <= sat_add(mm01_ff, mm2_ff);
         mh_ff   <= sat_add(mh01_ff, mh2_ff);

         div_rem_ff[0] <= 64'(div_num >> QB);
         div_n_ff[0]   <= div_num[QB-1:0];
         div_den_ff[0] <= den_ff;
         div_q_ff[0]   <= '0;
         for (int j = 1; j <= QB; j++) begin
            div_rem_ff[j] <= div_rem_in[j];
            div_q_ff[j]   <= div_q_in[j];
            div_n_ff[j]   <= div_n_ff[j-1];
            div_den_ff[j] <= div_den_ff[j-1];
         end
         negg_ff <= -word_type'({1'b0, div_q_ff[QB]});

         omm_p[T_OMM] <= sat_sub(FX_ONE, mm_ff);
         for (int k = T_OMM + 1; k <= T_C; k++) omm_p[k] <= omm_p[k-1];

         for (int i = 0; i < 3; i++) begin
            hp_ff[i]     <= sat_sub(hp1[i], hp2[i]);
            cr_ff[i]     <= prec_ff ? sat_sub(cra[i], crb[i]) : '0;
            hpa_ff[i]    <= hpa[i];
            t_p[T_T][i]  <= sat_sub(cr_ff[i], hpa_ff[i]);
            dm_p[T_DM+1][i] <= dm_w[i];
         end
         for (int k = T_T + 1; k <= T_G; k++) t_p[k] <= t_p[k-1];
         for (int k = T_DM + 2; k <= T_KM; k++) dm_p[k] <= dm_p[k-1];

         s01_ff <= sat_add(sp[0], sp[1]);
         s2_ff  <= sp[2];
         s_ff   <= sat_add(s01_ff, s2_ff);

         // The sum of squares is never negative.
         sq_rem_ff[0] <= TW'($unsigned(s_ff)) << FRAC_BITS;
         sq_r_ff[0]   <= '0;
         for (int j = 1; j <= SQB; j++) begin
            sq_rem_ff[j] <= sq_rem_in[j];
            sq_r_ff[j]   <= sq_r_in[j];
         end
         c_ff <= corr_ff[WORD_W-1] ? word_type'(six_r) : corr_ff;

         for (int i = 0; i < 3; i++) begin
            out_ff[i] <= ctl_p[T_KM][1] ? '0 : sat_add(dm_p[T_KM][i], kmp[i]);
         end
         last_ff <= ctl_p[T_KM][0];
      end
   end

   generate
      for (genvar i = 0; i < 3; i++) begin : g_lane
         llg_fmul u_mm (.clock(clock), .en(en), .a(m_p[0][i]), .b(m_p[0][i]), .p(mmp[i]));
         llg_fmul u_mh (.clock(clock), .en(en), .a(m_p[0][i]), .b(h_p[0][i]), .p(mhp[i]));
         llg_fmul u_hp1 (.clock(clock), .en(en), .a(mm_ff), .b(h_p[T_DOT][i]), .p(hp1[i]));
         llg_fmul u_hp2 (.clock(clock), .en(en), .a(mh_ff), .b(m_p[T_DOT][i]), .p(hp2[i]));
         llg_fmul u_cra (.clock(clock), .en(en), .a(m_p[T_HP][(i+1)%3]),
                         .b(hp_ff[(i+2)%3]), .p(cra[i]));
         llg_fmul u_crb (.clock(clock), .en(en), .a(m_p[T_HP][(i+2)%3]),
                         .b(hp_ff[(i+1)%3]), .p(crb[i]));
         llg_fmul u_hpa (.clock(clock), .en(en), .a(hp_ff[i]), .b(a_p[T_HP]), .p(hpa[i]));
         llg_fmul u_dm (.clock(clock), .en(en), .a(negg_ff), .b(t_p[T_G][i]), .p(dm_w[i]));
         llg_fmul u_sq (.clock(clock), .en(en), .a(dm_w[i]), .b(dm_w[i]), .p(sp[i]));
         llg_fmul u_km (.clock(clock), .en(en), .a(kp), .b(m_p[T_K][i]), .p(kmp[i]));
      end
   endgenerate

   llg_fmul u_aa (.clock(clock), .en(en), .a(a_p[0]), .b(a_p[0]), .p(aap));
   llg_fmul u_k (.clock(clock), .en(en), .a(c_ff), .b(omm_p[T_C]), .p(kp));

   // Valid bits and the skid register at the output.
   word_type skid_dm_ff [3];
   logic     skid_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff      <= '0;
         skid_v_ff <= 1'b0;
      end else begin
         if (en) begin
            v_ff <= {v_ff[T_OUT-1:0], req.valid};
         end
         if (skid_v_ff && rsp.ready) begin
            skid_v_ff <= 1'b0;
         end else if (en && v_ff[T_OUT] && !rsp.ready) begin
            skid_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en && v_ff[T_OUT] && !rsp.ready) begin
         skid_dm_ff   <= out_ff;
         skid_last_ff <= last_ff;
      end
   end

   assign rsp.valid    = skid_v_ff || v_ff[T_OUT];
   assign rsp.dm_x     = skid_v_ff ? skid_dm_ff[0] : out_ff[0];
   assign rsp.dm_y     = skid_v_ff ? skid_dm_ff[1] : out_ff[1];
   assign rsp.dm_z     = skid_v_ff ? skid_dm_ff[2] : out_ff[2];
   assign rsp.last_out = skid_v_ff ? skid_last_ff : last_ff;

endmodule

// ===== sv/llg_fmul.sv =====
module llg_fmul import llg_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  word_type a,
   input  word_type b,
   output word_type p
);

   logic              neg1_ff;
   logic [63:0]       am_ff;
   logic [63:0]       bm_ff;
   logic              neg2_ff;
   logic [63:0]       ll_ff;
   logic [63:0]       lh_ff;
   logic [63:0]       hl_ff;
   logic [63:0]       hh_ff;
   logic              neg3_ff;
   logic [127:0]      sum_ff;
   logic [127:0]      sum_in;
   logic [63:0]       mag_in;
   word_type          p_ff;

   // Partial products are recombined with the rounding half added in.
   assign sum_in = {64'd0, ll_ff} + {32'd0, lh_ff, 32'd0} + {32'd0, hl_ff, 32'd0}
                 + {hh_ff, 64'd0} + (128'd1 << (FRAC_BITS - 1));

   assign mag_in = (|sum_ff[127:FRAC_BITS+64]) ? {64{1'b1}}
                                                : sum_ff[FRAC_BITS+63:FRAC_BITS];

   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff <= a[63] ^ b[63];
         am_ff   <= mag64(a);
         bm_ff   <= mag64(b);
         neg2_ff <= neg1_ff;
         ll_ff   <= {32'd0, am_ff[31:0]}  * {32'd0, bm_ff[31:0]};
         lh_ff   <= {32'd0, am_ff[31:0]}  * {32'd0, bm_ff[63:32]};
         hl_ff   <= {32'd0, am_ff[63:32]} * {32'd0, bm_ff[31:0]};
         hh_ff   <= {32'd0, am_ff[63:32]} * {32'd0, bm_ff[63:32]};
         neg3_ff <= neg2_ff;
         sum_ff  <= sum_in;
         p_ff    <= from_mag(mag_in, neg3_ff);
      end
   end

   assign p = p_ff;

endmodule
